/* sv/ghc_pkg.sv */
// ----------------------------------------------------------------------------
// ghc_pkg
// Shared types and constants of the greenhouse climate controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ghc_pkg;

  localparam int MOISTURE_SAMPLE_COUNT = 5;
  localparam int SAMPLE_W = 10;
  localparam int TEMP_W = 12;
  localparam int TOL_W = 9;
  localparam int TIME_W = 32;
  localparam int SUM_W = 13;
  localparam int THR_W = 14;

  // sum / 5 == (sum * AVG_MUL) >> AVG_SHIFT, exact for every 13-bit sum
  localparam int AVG_MUL_W = 16;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL = 16'd52429;
  localparam int AVG_SHIFT = 18;
  localparam int PROD_W = SUM_W + AVG_MUL_W;

  localparam int ADDR_W = 5;
  localparam int IDX_W = 3;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] REG_TARGET_TEMP = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_TOL = 3'd1;
  localparam logic [IDX_W-1:0] REG_FAN_HUM = 3'd2;
  localparam logic [IDX_W-1:0] REG_LIGHT_ON = 3'd3;
  localparam logic [IDX_W-1:0] REG_LIGHT_OFF = 3'd4;
  localparam logic [IDX_W-1:0] REG_SOIL_DRY = 3'd5;
  localparam logic [IDX_W-1:0] REG_PUMP_RUN = 3'd6;
  localparam logic [IDX_W-1:0] REG_PUMP_PAUSE = 3'd7;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temperature;
    logic [TOL_W-1:0] temperature_tolerance;
    logic [SAMPLE_W-1:0] fan_humidity_above;
    logic [SAMPLE_W-1:0] light_on_below;
    logic [SAMPLE_W-1:0] light_off_above;
    logic [SAMPLE_W-1:0] soil_dry_below;
    logic [TIME_W-1:0] pump_run_ms;
    logic [TIME_W-1:0] pump_pause_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_temperature: 12'sd250,
    temperature_tolerance: 9'd20,
    fan_humidity_above: 10'd550,
    light_on_below: 10'd450,
    light_off_above: 10'd550,
    soil_dry_below: 10'd350,
    pump_run_ms: 32'd3000,
    pump_pause_ms: 32'd30000
  };

endpackage

`default_nettype wire

/* sv/greenhouse_climate_controller.sv */
// ----------------------------------------------------------------------------
// greenhouse_climate_controller
// One control tick in, one actuator result out.
// ----------------------------------------------------------------------------
// Each input transaction on s_axis is one control tick: temperature, humidity,
// light level, five soil moisture samples and the millisecond time. Each tick
// yields exactly one output transaction on m_axis with the grow light, pump,
// heater and fan commands and the truncated moisture average.
// The moisture samples are summed into the input register; the average
// (reciprocal multiply), hysteresis and pump timing are resolved between the
// input register and the output register, where the controller state updates.
// The result of a tick reaches m_axis through the input register and then the
// output register, which drives m_axis_tvalid.
// Throughput is one tick per cycle while m_axis is not stalled, set by the single compute stage.
// A stalled m_axis holds its result; the input register still takes one more
// tick, and s_axis_tready drops only when both registers are full.
// Synchronous reset clears both valid flags and the controller state and
// loads the registers with their defaults. Thresholds are to be written over
// APB only while no tick is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module greenhouse_climate_controller (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // tdata: temperature_tenths[11:0], humidity_tenths[21:12], light_level[31:22],
  //        moisture_sample_0..4[81:32] (10 bits each), now_ms[113:82]
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [119:0]                s_axis_tdata,
  // tdata: grow_light_on[0], pump_running[1], heater_running[2],
  //        fan_running[3], moisture_average[13:4]
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [15:0]                 m_axis_tdata,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ghc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ghc_pkg::DATA_W-1:0]  pwdata,
  output logic      [ghc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import ghc_pkg::*;

  cfg_t cfg;

  ghc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic                     in_valid;
  logic signed [TEMP_W-1:0] in_temp;
  logic [SAMPLE_W-1:0]      in_hum;
  logic [SAMPLE_W-1:0]      in_light;
  logic [SUM_W-1:0]         in_sum;
  logic [TIME_W-1:0]        in_now;

  logic                     light_flag;
  logic                     heater_flag;
  logic                     pump_flag;
  logic [TIME_W-1:0]        pump_started_at;
  logic [TIME_W-1:0]        pump_stopped_at;

  logic                     light_flag_next;
  logic                     heater_flag_next;
  logic                     pump_flag_next;
  logic [TIME_W-1:0]        pump_started_at_next;
  logic [TIME_W-1:0]        pump_stopped_at_next;

  logic                     out_valid;
  logic [15:0]              out_data;

  logic                     advance;
  logic [SUM_W-1:0]         sample_sum;
  logic [PROD_W-1:0]        avg_prod;
  logic [SAMPLE_W-1:0]      avg;
  logic signed [THR_W-1:0]  temp_x;
  logic signed [THR_W-1:0]  target_x;
  logic signed [THR_W-1:0]  tol_x;
  logic signed [THR_W-1:0]  heat_on_thr;
  logic signed [THR_W-1:0]  fan_temp_thr;
  logic [TIME_W-1:0]        since_stop;
  logic [TIME_W-1:0]        since_start;
  logic                     dry;
  logic                     fan;

  assign advance = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    sample_sum = '0;
    for (int i = 0; i < MOISTURE_SAMPLE_COUNT; i++) begin
      sample_sum = sample_sum + SUM_W'(s_axis_tdata[32 + SAMPLE_W*i +: SAMPLE_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_temp  <= s_axis_tdata[11:0];
      in_hum   <= s_axis_tdata[21:12];
      in_light <= s_axis_tdata[31:22];
      in_sum   <= sample_sum;
      in_now   <= s_axis_tdata[113:82];
    end
  end

  assign avg_prod = PROD_W'(in_sum) * PROD_W'(AVG_MUL);
  assign avg = avg_prod[AVG_SHIFT +: SAMPLE_W];

  assign temp_x = THR_W'(in_temp);
  assign target_x = THR_W'(cfg.target_temperature);
  assign tol_x = signed'(THR_W'(cfg.temperature_tolerance));
  assign heat_on_thr = target_x - tol_x;
  assign fan_temp_thr = target_x + tol_x;

  assign since_stop = in_now - pump_stopped_at;
  assign since_start = in_now - pump_started_at;
  assign dry = avg < cfg.soil_dry_below;

  always_comb begin
    light_flag_next = light_flag;
    if (in_light < cfg.light_on_below) begin
      light_flag_next = 1'b1;
    end else if (in_light > cfg.light_off_above) begin
      light_flag_next = 1'b0;
    end

    heater_flag_next = heater_flag;
    if (temp_x < heat_on_thr) begin
      heater_flag_next = 1'b1;
    end else if (temp_x > target_x) begin
      heater_flag_next = 1'b0;
    end

    pump_flag_next = pump_flag;
    pump_started_at_next = pump_started_at;
    pump_stopped_at_next = pump_stopped_at;
    if (dry) begin
      if (!pump_flag) begin
        if (since_stop >= cfg.pump_pause_ms) begin
          pump_flag_next = 1'b1;
          pump_started_at_next = in_now;
        end
      end else if (since_start >= cfg.pump_run_ms) begin
        pump_flag_next = 1'b0;
        pump_stopped_at_next = in_now;
      end
    end else if (pump_flag) begin
      pump_flag_next = 1'b0;
      pump_stopped_at_next = in_now;
    end

    fan = (in_hum > cfg.fan_humidity_above) || (temp_x > fan_temp_thr) || heater_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_flag      <= 1'b0;
      heater_flag     <= 1'b0;
      pump_flag       <= 1'b0;
      pump_started_at <= '0;
      pump_stopped_at <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        light_flag      <= light_flag_next;
        heater_flag     <= heater_flag_next;
        pump_flag       <= pump_flag_next;
        pump_started_at <= pump_started_at_next;
        pump_stopped_at <= pump_stopped_at_next;
        out_valid       <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= {2'b00, avg, fan, heater_flag_next, pump_flag_next, light_flag_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  a_heater_fan: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[2] || m_axis_tdata[3]))
    else $error("heater on without fan");

  a_pump_start: assert property (@(posedge clk) disable iff (rst)
    $rose(pump_flag) |-> (pump_started_at == $past(in_now)))
    else $error("pump start time not captured");

  a_pump_stop: assert property (@(posedge clk) disable iff (rst)
    $fell(pump_flag) |-> (pump_stopped_at == $past(in_now)))
    else $error("pump stop time not captured");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(pump_flag) && $stable(light_flag) && $stable(heater_flag)))
    else $error("controller state changed without a tick");

endmodule

`default_nettype wire

/* sv/ghc_regs.sv */
// ----------------------------------------------------------------------------
// ghc_regs
// APB register file holding the controller thresholds and pump limits.
// ----------------------------------------------------------------------------
`default_nettype none

module ghc_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ghc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ghc_pkg::DATA_W-1:0]  pwdata,
  output logic      [ghc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output ghc_pkg::cfg_t                    cfg
);
  import ghc_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_TARGET_TEMP: cfg.target_temperature <= pwdata[TEMP_W-1:0];
        REG_TEMP_TOL:    cfg.temperature_tolerance <= pwdata[TOL_W-1:0];
        REG_FAN_HUM:     cfg.fan_humidity_above <= pwdata[SAMPLE_W-1:0];
        REG_LIGHT_ON:    cfg.light_on_below <= pwdata[SAMPLE_W-1:0];
        REG_LIGHT_OFF:   cfg.light_off_above <= pwdata[SAMPLE_W-1:0];
        REG_SOIL_DRY:    cfg.soil_dry_below <= pwdata[SAMPLE_W-1:0];
        REG_PUMP_RUN:    cfg.pump_run_ms <= pwdata;
        REG_PUMP_PAUSE:  cfg.pump_pause_ms <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_TEMP: prdata = DATA_W'(unsigned'(cfg.target_temperature));
      REG_TEMP_TOL:    prdata = DATA_W'(cfg.temperature_tolerance);
      REG_FAN_HUM:     prdata = DATA_W'(cfg.fan_humidity_above);
      REG_LIGHT_ON:    prdata = DATA_W'(cfg.light_on_below);
      REG_LIGHT_OFF:   prdata = DATA_W'(cfg.light_off_above);
      REG_SOIL_DRY:    prdata = DATA_W'(cfg.soil_dry_below);
      REG_PUMP_RUN:    prdata = cfg.pump_run_ms;
      REG_PUMP_PAUSE:  prdata = cfg.pump_pause_ms;
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the greenhouse climate controller.
// ----------------------------------------------------------------------------
// Control ticks go in on s_axis and actuator results come back on m_axis.
// A behavioral model of the hysteresis, pump timing and moisture average
// predicts each result when its tick is accepted. The result checker compares
// every output transaction field by field in order. Thresholds are written
// and read back over APB while the pipeline is empty. Directed ticks cover
// the field extremes, the hysteresis boundaries, overlapping thresholds, zero
// pump limits, the early-start rule and time wrap. Random ticks then run near
// the thresholds under several threshold settings and idling patterns.
// ----------------------------------------------------------------------------

module testbench;
  import ghc_pkg::*;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [4:0][9:0] moisture;
    logic [9:0] light_level;
    logic [9:0] humidity;
    logic signed [11:0] temperature;
  } tick_t;

  typedef struct packed {
    logic [9:0] moisture_average;
    logic fan;
    logic heater;
    logic pump;
    logic grow_light;
  } actuators_t;

  typedef enum logic [1:0] {CFG_RANDOM, CFG_LOWEST, CFG_HIGHEST} cfg_choice_e;

  localparam int SEND_IDLE_PCT [4] = '{0, 78, 0, 6};
  localparam int STALL_PCT [4] = '{0, 0, 78, 6};
  localparam int RANDOM_SEGMENTS = 8;
  localparam int TICKS_PER_SEGMENT = 235;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  cfg_t thresholds = CFG_RESET;
  logic lamp_on = 1'b0;
  logic heater_on = 1'b0;
  logic pump_on = 1'b0;
  logic [31:0] pump_start_ms = '0;
  logic [31:0] pump_stop_ms = '0;

  actuators_t pending_results[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_idle_pct = 0;
  logic [31:0] sim_ms = '0;

  greenhouse_climate_controller u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic actuators_t predict_tick(tick_t t);
    actuators_t r;
    logic [12:0] sum;
    logic [31:0] elapsed;
    int temp;
    int target;
    int tol;
    sum = '0;
    for (int i = 0; i < MOISTURE_SAMPLE_COUNT; i++) sum += t.moisture[i];
    r.moisture_average = 10'(sum / 13'd5);
    if (t.light_level < thresholds.light_on_below) begin
      lamp_on = 1'b1;
    end else if (t.light_level > thresholds.light_off_above) begin
      lamp_on = 1'b0;
    end
    if (r.moisture_average < thresholds.soil_dry_below) begin
      if (!pump_on) begin
        elapsed = t.now_ms - pump_stop_ms;
        if (elapsed >= thresholds.pump_pause_ms) begin
          pump_on = 1'b1;
          pump_start_ms = t.now_ms;
        end
      end else begin
        elapsed = t.now_ms - pump_start_ms;
        if (elapsed >= thresholds.pump_run_ms) begin
          pump_on = 1'b0;
          pump_stop_ms = t.now_ms;
        end
      end
    end else if (pump_on) begin
      pump_on = 1'b0;
      pump_stop_ms = t.now_ms;
    end
    temp = $signed(t.temperature);
    target = $signed(thresholds.target_temperature);
    tol = int'(thresholds.temperature_tolerance);
    if (temp < target - tol) begin
      heater_on = 1'b1;
    end else if (temp > target) begin
      heater_on = 1'b0;
    end
    r.fan = (t.humidity > thresholds.fan_humidity_above) || (temp > target + tol) || heater_on;
    r.grow_light = lamp_on;
    r.pump = pump_on;
    r.heater = heater_on;
    return r;
  endfunction

  function automatic void compare_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    actuators_t got;
    actuators_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[13:0];
      if (pending_results.size() == 0) begin
        $error("result with no tick pending: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("grow_light_on", want.grow_light, got.grow_light);
        compare_field("pump_running", want.pump, got.pump);
        compare_field("heater_running", want.heater, got.heater);
        compare_field("fan_running", want.fan, got.fan);
        compare_field("moisture_average", want.moisture_average, got.moisture_average);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_idle_pct);
  end

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, t};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_tick(t));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [IDX_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] register_value(input logic [IDX_W-1:0] idx,
                                                 output logic [31:0] mask);
    case (idx)
      REG_TARGET_TEMP: begin
        mask = 32'hFFF;
        return {20'd0, thresholds.target_temperature};
      end
      REG_TEMP_TOL: begin
        mask = 32'h1FF;
        return {23'd0, thresholds.temperature_tolerance};
      end
      REG_FAN_HUM: begin
        mask = 32'h3FF;
        return {22'd0, thresholds.fan_humidity_above};
      end
      REG_LIGHT_ON: begin
        mask = 32'h3FF;
        return {22'd0, thresholds.light_on_below};
      end
      REG_LIGHT_OFF: begin
        mask = 32'h3FF;
        return {22'd0, thresholds.light_off_above};
      end
      REG_SOIL_DRY: begin
        mask = 32'h3FF;
        return {22'd0, thresholds.soil_dry_below};
      end
      REG_PUMP_RUN: begin
        mask = 32'hFFFF_FFFF;
        return thresholds.pump_run_ms;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        return thresholds.pump_pause_ms;
      end
    endcase
  endfunction

  task automatic check_register(input logic [IDX_W-1:0] idx);
    logic [31:0] rd;
    logic [31:0] mask;
    logic [31:0] want;
    apb_access(1'b0, idx, 32'd0, rd);
    want = register_value(idx, mask);
    if ((rd & mask) != want) begin
      $error("register %0d: expected %h, actual %h", idx, want, rd & mask);
      error_count++;
    end
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] ignored;
    apb_access(1'b1, idx, value, ignored);
    case (idx)
      REG_TARGET_TEMP: thresholds.target_temperature = value[11:0];
      REG_TEMP_TOL: thresholds.temperature_tolerance = value[8:0];
      REG_FAN_HUM: thresholds.fan_humidity_above = value[9:0];
      REG_LIGHT_ON: thresholds.light_on_below = value[9:0];
      REG_LIGHT_OFF: thresholds.light_off_above = value[9:0];
      REG_SOIL_DRY: thresholds.soil_dry_below = value[9:0];
      REG_PUMP_RUN: thresholds.pump_run_ms = value;
      REG_PUMP_PAUSE: thresholds.pump_pause_ms = value;
      default: ;
    endcase
    check_register(idx);
  endtask

  function automatic tick_t build_tick(int temp, int hum, int light, int moist,
                                       logic [31:0] now);
    tick_t t;
    t.temperature = 12'(temp);
    t.humidity = 10'(hum);
    t.light_level = 10'(light);
    for (int i = 0; i < MOISTURE_SAMPLE_COUNT; i++) t.moisture[i] = 10'(moist);
    t.now_ms = now;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    logic [127:0] raw;
    int target;
    int tol;
    int level;
    int soil;
    raw = {$urandom, $urandom, $urandom, $urandom};
    t = raw[113:0];
    if ($urandom_range(9) == 0) return t;
    target = $signed(thresholds.target_temperature);
    tol = int'(thresholds.temperature_tolerance);
    sim_ms += $urandom_range(1500);
    t.now_ms = sim_ms;
    t.temperature = 12'(target - tol - 10 + int'($urandom_range(2 * tol + 20)));
    t.humidity = 10'(int'(thresholds.fan_humidity_above) + int'($urandom_range(30)) - 15);
    level = $urandom_range(1) ? int'(thresholds.light_on_below)
                              : int'(thresholds.light_off_above);
    t.light_level = 10'(level + int'($urandom_range(40)) - 20);
    soil = int'(thresholds.soil_dry_below) + int'($urandom_range(40)) - 28;
    for (int i = 0; i < MOISTURE_SAMPLE_COUNT; i++) begin
      t.moisture[i] = 10'(soil + int'($urandom_range(8)) - 4);
    end
    return t;
  endfunction

  task automatic apply_config(input cfg_choice_e choice);
    int on_level;
    case (choice)
      CFG_LOWEST: begin
        write_register(REG_TARGET_TEMP, -400);
        write_register(REG_TEMP_TOL, 0);
        write_register(REG_FAN_HUM, 0);
        write_register(REG_LIGHT_ON, 0);
        write_register(REG_LIGHT_OFF, 0);
        write_register(REG_SOIL_DRY, 0);
        write_register(REG_PUMP_RUN, 0);
        write_register(REG_PUMP_PAUSE, 0);
      end
      CFG_HIGHEST: begin
        write_register(REG_TARGET_TEMP, 1250);
        write_register(REG_TEMP_TOL, 500);
        write_register(REG_FAN_HUM, 1000);
        write_register(REG_LIGHT_ON, 1023);
        write_register(REG_LIGHT_OFF, 1023);
        write_register(REG_SOIL_DRY, 1023);
        write_register(REG_PUMP_RUN, 32'hFFFF_FFFF);
        write_register(REG_PUMP_PAUSE, 32'hFFFF_FFFF);
      end
      default: begin
        on_level = $urandom_range(900);
        write_register(REG_TARGET_TEMP, $urandom_range(1650) - 400);
        write_register(REG_TEMP_TOL, $urandom_range(80));
        write_register(REG_FAN_HUM, $urandom_range(1000));
        write_register(REG_LIGHT_ON, on_level);
        write_register(REG_LIGHT_OFF, on_level + int'($urandom_range(150)) - 30);
        write_register(REG_SOIL_DRY, $urandom_range(700, 200));
        write_register(REG_PUMP_RUN, ($urandom_range(7) == 0) ? $urandom : $urandom_range(6000));
        write_register(REG_PUMP_PAUSE,
                       ($urandom_range(7) == 0) ? $urandom : $urandom_range(8000));
      end
    endcase
  endtask

  task automatic test_register_reset_values();
    for (int i = 0; i <= REG_PUMP_PAUSE; i++) check_register(IDX_W'(i));
  endtask

  task automatic test_directed_ticks();
    tick_t t;
    send_tick(build_tick(-400, 0, 0, 0, 32'd0));
    send_tick(build_tick(1250, 1000, 1023, 1023, 32'd1));
    send_tick(build_tick(250, 550, 500, 200, 32'd29999));
    send_tick(build_tick(229, 551, 449, 200, 32'd30000));
    send_tick(build_tick(230, 0, 550, 200, 32'd32999));
    send_tick(build_tick(271, 0, 551, 200, 32'd33000));
    send_tick(build_tick(270, 0, 500, 200, 32'd62999));
    send_tick(build_tick(250, 1023, 500, 200, 32'd63000));
    t = build_tick(250, 0, 500, 350, 32'd63001);
    t.moisture[0] = 10'd349;
    t.moisture[1] = 10'd349;
    t.moisture[4] = 10'd351;
    send_tick(t);
    t.moisture[1] = 10'd350;
    t.now_ms = 32'd63002;
    send_tick(t);
    send_tick(build_tick(-2048, 0, 0, 0, 32'hFFFF_FFF0));
    send_tick(build_tick(2047, 0, 1023, 0, 32'd2983));
    send_tick(build_tick(0, 0, 0, 0, 32'd2984));
    t = build_tick(0, 0, 0, 1023, 32'd2985);
    t.moisture[4] = 10'd1019;
    send_tick(t);
  endtask

  task automatic test_threshold_corners();
    wait_for_results();
    write_register(REG_LIGHT_ON, 32'hFFFF_0000 | 32'd600);
    write_register(REG_LIGHT_OFF, 400);
    send_tick(build_tick(250, 0, 700, 500, 32'd5000));
    send_tick(build_tick(250, 0, 500, 500, 32'd5001));
    send_tick(build_tick(250, 0, 600, 500, 32'd5002));
    wait_for_results();
    write_register(REG_TEMP_TOL, 0);
    write_register(REG_TARGET_TEMP, -400);
    send_tick(build_tick(-401, 0, 600, 500, 32'd5003));
    send_tick(build_tick(-400, 0, 600, 500, 32'd5004));
    send_tick(build_tick(-399, 0, 600, 500, 32'd5005));
    wait_for_results();
    write_register(REG_TARGET_TEMP, 1250);
    write_register(REG_TEMP_TOL, 500);
    send_tick(build_tick(749, 0, 600, 500, 32'd5006));
    send_tick(build_tick(2047, 0, 600, 500, 32'd5007));
    wait_for_results();
    write_register(REG_PUMP_RUN, 0);
    write_register(REG_PUMP_PAUSE, 0);
    write_register(REG_SOIL_DRY, 1023);
    send_tick(build_tick(250, 0, 600, 1022, 32'd100));
    send_tick(build_tick(250, 0, 600, 1022, 32'd100));
    send_tick(build_tick(250, 0, 600, 1022, 32'd101));
    send_tick(build_tick(250, 0, 600, 1022, 32'd101));
  endtask

  task automatic test_random_ticks();
    cfg_choice_e choice;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      wait_for_results();
      choice = (seg == 1) ? CFG_LOWEST : (seg == 2) ? CFG_HIGHEST : CFG_RANDOM;
      apply_config(choice);
      send_idle_pct = SEND_IDLE_PCT[seg % 4];
      stall_idle_pct = STALL_PCT[seg % 4];
      for (int n = 0; n < TICKS_PER_SEGMENT; n++) send_tick(random_tick());
    end
    send_idle_pct = 0;
    stall_idle_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_register_reset_values();
    test_directed_ticks();
    test_threshold_corners();
    test_random_ticks();
    wait_for_results();
    repeat (6) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
